>>> rtl/mahd_pkg.sv
// Package for the MPEG audio header decoder: codes, lookup tables and shared types.
package mahd_pkg;

    localparam int WORD_W    = 32;
    localparam int KBPS_W    = 9;
    localparam int HZ_W      = 16;
    localparam int LEN_W     = 11;
    localparam int COEF_W    = 18;
    localparam int NUM_W     = 26;
    localparam int RECIP_W   = 28;
    localparam int RECIP_SHIFT = 40;
    localparam int QPROD_W   = LEN_W + HZ_W;

    localparam logic [11:0]     SYNC_PATTERN   = 12'hFFE;
    localparam logic [3:0]      BAD_RATE_INDEX = 4'h0F;
    localparam logic [1:0]      BAD_FREQ_INDEX = 2'd3;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = LEN_W'(21);

    localparam logic [1:0] VER_MPEG2  = 2'd0;
    localparam logic [1:0] VER_MPEG1  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    localparam logic [1:0] LAYER_RSVD = 2'd0;
    localparam logic [1:0] LAYER_III  = 2'd1;
    localparam logic [1:0] LAYER_II   = 2'd2;
    localparam logic [1:0] LAYER_I    = 2'd3;

    localparam logic [COEF_W-1:0] COEF_L23 = COEF_W'(72000);
    localparam logic [COEF_W-1:0] COEF_L1  = COEF_W'(24000);

    // floor(2^40 / hz) for each sample rate
    localparam logic [RECIP_W-1:0] RECIP_44100 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd44100);
    localparam logic [RECIP_W-1:0] RECIP_48000 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd48000);
    localparam logic [RECIP_W-1:0] RECIP_32000 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd32000);
    localparam logic [RECIP_W-1:0] RECIP_22050 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd22050);
    localparam logic [RECIP_W-1:0] RECIP_24000 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd24000);
    localparam logic [RECIP_W-1:0] RECIP_16000 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd16000);
    localparam logic [RECIP_W-1:0] RECIP_11025 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd11025);
    localparam logic [RECIP_W-1:0] RECIP_12000 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd12000);
    localparam logic [RECIP_W-1:0] RECIP_8000  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd8000);

    localparam logic [KBPS_W-1:0] KBPS_M2_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_M2_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_M1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_M1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_M1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};

    typedef struct packed {
        logic              ok;
        logic [1:0]        ver;
        logic [1:0]        layer;
        logic [KBPS_W-1:0] kbps;
        logic [HZ_W-1:0]   hz;
        logic              pad;
        logic              crc;
        logic [1:0]        chmode;
        logic [1:0]        modeext;
        logic [1:0]        emph;
    } hdr_fields_t;

    function automatic logic [KBPS_W-1:0] kbps_lookup(input logic mpeg1,
                                                      input logic [1:0] layer,
                                                      input logic [3:0] bri);
        logic [KBPS_W-1:0] kbps;
        kbps = '0;
        unique case (layer)
            LAYER_III: kbps = mpeg1 ? KBPS_M1_L3[bri] : KBPS_M2_L23[bri];
            LAYER_II:  kbps = mpeg1 ? KBPS_M1_L2[bri] : KBPS_M2_L23[bri];
            LAYER_I:   kbps = mpeg1 ? KBPS_M1_L1[bri] : KBPS_M2_L1[bri];
            default:   kbps = '0;
        endcase
        return kbps;
    endfunction

    function automatic logic [HZ_W-1:0] hz_lookup(input logic [1:0] ver,
                                                  input logic [1:0] fri);
        logic [HZ_W-1:0] hz;
        hz = '0;
        unique case ({ver, fri})
            {VER_MPEG2, 2'd0}:  hz = 16'd22050;
            {VER_MPEG2, 2'd1}:  hz = 16'd24000;
            {VER_MPEG2, 2'd2}:  hz = 16'd16000;
            {VER_MPEG1, 2'd0}:  hz = 16'd44100;
            {VER_MPEG1, 2'd1}:  hz = 16'd48000;
            {VER_MPEG1, 2'd2}:  hz = 16'd32000;
            {VER_MPEG25, 2'd0}: hz = 16'd11025;
            {VER_MPEG25, 2'd1}: hz = 16'd12000;
            {VER_MPEG25, 2'd2}: hz = 16'd8000;
            default:            hz = '0;
        endcase
        return hz;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [1:0] ver,
                                                        input logic [1:0] fri);
        logic [RECIP_W-1:0] r;
        r = '0;
        unique case ({ver, fri})
            {VER_MPEG2, 2'd0}:  r = RECIP_22050;
            {VER_MPEG2, 2'd1}:  r = RECIP_24000;
            {VER_MPEG2, 2'd2}:  r = RECIP_16000;
            {VER_MPEG1, 2'd0}:  r = RECIP_44100;
            {VER_MPEG1, 2'd1}:  r = RECIP_48000;
            {VER_MPEG1, 2'd2}:  r = RECIP_32000;
            {VER_MPEG25, 2'd0}: r = RECIP_11025;
            {VER_MPEG25, 2'd1}: r = RECIP_12000;
            {VER_MPEG25, 2'd2}: r = RECIP_8000;
            default:            r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/mahd_field_decode.sv
// Stage 1: header field split, validity checks and table lookups.
module mahd_field_decode
    import mahd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [WORD_W-1:0]   word,
    output logic                out_valid,
    output hdr_fields_t         fields,
    output logic [COEF_W-1:0]   coef,
    output logic [RECIP_W-1:0]  recip
);

    logic               valid_reg;
    hdr_fields_t        fields_reg, fields_next;
    logic [COEF_W-1:0]  coef_reg, coef_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;

    logic [1:0] ver;
    logic [1:0] layer;
    logic [3:0] bri;
    logic [1:0] fri;
    logic       ok;

    always_comb
    begin
        ver   = word[20] ? {1'b0, word[19]} : VER_MPEG25;
        layer = word[18:17];
        bri   = word[15:12];
        fri   = word[11:10];
        ok    = ({word[31:21], 1'b0} == SYNC_PATTERN) && (layer != LAYER_RSVD)
                && (bri != BAD_RATE_INDEX) && (fri != BAD_FREQ_INDEX);

        fields_next.ok      = ok;
        fields_next.ver     = ver;
        fields_next.layer   = layer;
        fields_next.kbps    = ok ? kbps_lookup(ver == VER_MPEG1, layer, bri) : '0;
        fields_next.hz      = ok ? hz_lookup(ver, fri) : '0;
        fields_next.pad     = word[9];
        fields_next.crc     = word[16];
        fields_next.chmode  = word[7:6];
        fields_next.modeext = word[5:4];
        fields_next.emph    = word[1:0];

        recip_next = ok ? recip_lookup(ver, fri) : '0;

        // coefficient times version multiplier
        case (layer)
            LAYER_I: coef_next = COEF_L1;
            default: coef_next = COEF_L23;
        endcase
        if (ver == VER_MPEG1)
        begin
            coef_next = coef_next << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fields_reg <= fields_next;
        coef_reg   <= coef_next;
        recip_reg  <= recip_next;
    end

    assign out_valid = valid_reg;
    assign fields    = fields_reg;
    assign coef      = coef_reg;
    assign recip     = recip_reg;

endmodule

>>> rtl/mahd_length_div.sv
// Stages 2 to 4: numerator product, reciprocal multiply and quotient back-product.
module mahd_length_div
    import mahd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  hdr_fields_t         in_fields,
    input  logic [COEF_W-1:0]   coef,
    input  logic [RECIP_W-1:0]  recip,
    output logic                out_valid,
    output hdr_fields_t         out_fields,
    output logic [NUM_W-1:0]    num,
    output logic [LEN_W-1:0]    quot_est,
    output logic [QPROD_W-1:0]  quot_prod
);

    logic               v2_reg, v3_reg, v4_reg;
    hdr_fields_t        f2_reg, f3_reg, f4_reg;
    logic [NUM_W-1:0]   num2_reg, num3_reg, num4_reg;
    logic [NUM_W-1:0]   num2_next;
    logic [RECIP_W-1:0] recip2_reg;
    logic [LEN_W-1:0]   q3_reg, q3_next, q4_reg;
    logic [QPROD_W-1:0] qp4_reg, qp4_next;
    logic [NUM_W+RECIP_W-1:0] recip_prod;

    always_comb
    begin
        num2_next  = NUM_W'(COEF_W'(coef) * (COEF_W + KBPS_W)'(in_fields.kbps));
        recip_prod = (NUM_W + RECIP_W)'(num2_reg) * (NUM_W + RECIP_W)'(recip2_reg);
        // low by at most one; fixed in the last stage
        q3_next    = recip_prod[RECIP_SHIFT +: LEN_W];
        qp4_next   = QPROD_W'(q3_reg) * QPROD_W'(f3_reg.hz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f2_reg     <= in_fields;
        num2_reg   <= num2_next;
        recip2_reg <= recip;
        f3_reg     <= f2_reg;
        num3_reg   <= num2_reg;
        q3_reg     <= q3_next;
        f4_reg     <= f3_reg;
        num4_reg   <= num3_reg;
        q4_reg     <= q3_reg;
        qp4_reg    <= qp4_next;
    end

    assign out_valid  = v4_reg;
    assign out_fields = f4_reg;
    assign num        = num4_reg;
    assign quot_est   = q4_reg;
    assign quot_prod  = qp4_reg;

endmodule

>>> rtl/mpeg_audio_header_decode.sv
// Top level of the MPEG audio frame header decoder: pipeline and result register.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------------
//  header   | header_word                               | start high, busy low
//  result   | header_valid .. emphasis_code             | done, one cycle, no stall
//
// Five register stages; one header word a cycle, result in the output register.
// The stages are decode, numerator, reciprocal multiply, back-product and correction.
// busy is never raised. Reset clears the valid bits only; results in flight are lost.
// The receiver cannot stall, so nothing is held back.
module mpeg_audio_header_decode
    import mahd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [WORD_W-1:0]   header_word,
    output logic                done,
    output logic                header_valid,
    output logic [1:0]          version_code,
    output logic [1:0]          layer_code,
    output logic [KBPS_W-1:0]   bitrate_kbps,
    output logic [HZ_W-1:0]     sample_rate_hz,
    output logic [LEN_W-1:0]    frame_bytes,
    output logic                crc_flag,
    output logic                padding_flag,
    output logic [1:0]          channel_mode,
    output logic [1:0]          mode_extension,
    output logic [1:0]          emphasis_code
);

    logic               s1_valid;
    hdr_fields_t        s1_fields;
    logic [COEF_W-1:0]  s1_coef;
    logic [RECIP_W-1:0] s1_recip;

    logic               s4_valid;
    hdr_fields_t        s4_fields;
    logic [NUM_W-1:0]   s4_num;
    logic [LEN_W-1:0]   s4_quot;
    logic [QPROD_W-1:0] s4_qprod;

    logic [QPROD_W-1:0] rem;
    logic               corr;
    logic [LEN_W-1:0]   len;
    logic               good;

    logic               done_reg;
    hdr_fields_t        res_reg, res_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    assign busy = 1'b0;

    mahd_field_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .word      (header_word),
        .out_valid (s1_valid),
        .fields    (s1_fields),
        .coef      (s1_coef),
        .recip     (s1_recip)
    );

    mahd_length_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_fields  (s1_fields),
        .coef       (s1_coef),
        .recip      (s1_recip),
        .out_valid  (s4_valid),
        .out_fields (s4_fields),
        .num        (s4_num),
        .quot_est   (s4_quot),
        .quot_prod  (s4_qprod)
    );

    always_comb
    begin
        rem  = QPROD_W'(s4_num) - s4_qprod;
        corr = s4_fields.ok && (rem >= QPROD_W'(s4_fields.hz));
        len  = s4_quot + LEN_W'(corr) + LEN_W'(s4_fields.pad);
        good = s4_fields.ok && (len >= MIN_FRAME_LEN);

        res_next    = good ? s4_fields : '0;
        res_next.ok = good;
        len_next    = good ? len : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        len_reg <= len_next;
    end

    assign done           = done_reg;
    assign header_valid   = res_reg.ok;
    assign version_code   = res_reg.ver;
    assign layer_code     = res_reg.layer;
    assign bitrate_kbps   = res_reg.kbps;
    assign sample_rate_hz = res_reg.hz;
    assign frame_bytes    = len_reg;
    assign crc_flag       = res_reg.crc;
    assign padding_flag   = res_reg.pad;
    assign channel_mode   = res_reg.chmode;
    assign mode_extension = res_reg.modeext;
    assign emphasis_code  = res_reg.emph;

    // result strobe follows each accepted header word through the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (rst_n && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
         && $past(rst_n, 4) && $past(rst_n, 5))
        |-> (done == $past(start && !busy, 5)))
        else $error("result strobe out of step with accepted words");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !header_valid) |-> (frame_bytes == '0 && bitrate_kbps == '0
            && sample_rate_hz == '0 && layer_code == LAYER_RSVD
            && version_code == VER_MPEG2))
        else $error("invalid header word with non-zero fields");

    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && header_valid) |-> (frame_bytes >= MIN_FRAME_LEN
            && sample_rate_hz != '0 && layer_code != LAYER_RSVD))
        else $error("valid header word with short frame or missing rate");

    a_valid_ver: assert property (@(posedge clk) disable iff (!rst_n)
        (done && header_valid) |-> (version_code == VER_MPEG1
            || version_code == VER_MPEG2 || version_code == VER_MPEG25))
        else $error("valid header word with reserved version");

endmodule
